// ===== src/sliding_window_frame_rate_defines.svh =====
// Assertion helpers shared by the RTL. They sample on clock and are
// disabled while reset is high.
`ifndef SLIDING_WINDOW_FRAME_RATE_DEFINES_SVH
`define SLIDING_WINDOW_FRAME_RATE_DEFINES_SVH

// property holds at every edge
`define SWFR_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("swfr invariant violated");

// same-cycle implication
`define SWFR_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("swfr implication violated");

// next-cycle implication
`define SWFR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("swfr next-cycle check violated");

`endif

// ===== src/swfr_pkg.sv =====
package swfr_pkg;

   // window register
   localparam int unsigned WINDOW_BITS = 26;
   localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 26'd1000000;

   // rate format: unsigned 16.8, saturating
   localparam int unsigned RATE_BITS = 24;
   localparam logic [RATE_BITS-1:0] RATE_MAX = 24'hFFFFFF;

   // one second in microseconds, scaled by 2^8 for the fraction bits
   localparam int unsigned SCALED_SECOND = 256000000;
   localparam int unsigned SCALE_BITS = 28;

   // configuration port
   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 32;
   localparam logic CSR_IDX_WINDOW = 1'b0;

   // divider handshake back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== src/swfr_ring_mem.sv =====
module swfr_ring_mem #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // one read port, registered data
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/swfr_divider.sv =====
module swfr_divider #(
   parameter int unsigned NUM_BITS = 35,
   parameter int unsigned DEN_BITS = 48
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [NUM_BITS-1:0]            dividend,
   input  logic [DEN_BITS-1:0]            divisor,
   output swfr_pkg::div_status_type       status,
   output logic [swfr_pkg::RATE_BITS-1:0] rate
);
   import swfr_pkg::*;

   localparam int unsigned CNT_BITS = $clog2(NUM_BITS + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [NUM_BITS-1:0] dvd_ff, dvd_in;
   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [DEN_BITS:0]   trial;
   logic [DEN_BITS:0]   diff;
   logic                fits;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, dvd_ff[NUM_BITS-1]};
      diff    = trial - {1'b0, den_ff};
      fits    = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_BITS'(NUM_BITS);
         dvd_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[NUM_BITS-2:0], 1'b0};
         quo_in = {quo_ff[NUM_BITS-2:0], fits};
         rem_in = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // saturate to the rate format
   assign rate = (|quo_ff[NUM_BITS-1:RATE_BITS]) ? RATE_MAX : quo_ff[RATE_BITS-1:0];
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== src/sliding_window_frame_rate.sv =====
// Frame-rate meter over a sliding time window.
// Request channel (req_valid/req_ready, req_timestamp_us): one frame arrival
// stamp in microseconds, nondecreasing. Response channel (rsp_valid/rsp_ready):
// exactly one result per request: rsp_rate_fps (unsigned 16.8, saturating),
// rsp_frames_in_window and rsp_ring_overflow.
// CSR port (APB style, pready always high): window_us at byte address 0.
// Write it only while no request is in flight.
// One request is processed at a time. The walk covers the stamps stored
// before the request plus its own, at most RING_DEPTH; the divider works on
// NUM_BITS = clog2(RING_DEPTH+1) + 28 bits (35 at the default depth). The
// time to a result is set by the walk over the stamp memory, one read per
// stamp through its single read port, and by the bit-serial divider. The
// next request can be taken in the same cycle that rsp_valid rises; if the
// receiver stalls, a finished result waits in the sequencer until the output
// register frees up, and no further request is taken meanwhile.
// Reset clears the ring (count and slot pointer), loads window_us with
// 1000000 and drops any pending response. No clearing pass is needed.
`include "sliding_window_frame_rate_defines.svh"

module sliding_window_frame_rate #(
   parameter int unsigned RING_DEPTH = 64,
   parameter int unsigned TIME_BITS  = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [TIME_BITS-1:0]                req_timestamp_us,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [swfr_pkg::RATE_BITS-1:0]      rsp_rate_fps,
   output logic [$clog2(RING_DEPTH+1)-1:0]     rsp_frames_in_window,
   output logic                                rsp_ring_overflow,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [swfr_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [swfr_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [swfr_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import swfr_pkg::*;

   localparam int unsigned ADDR_BITS = $clog2(RING_DEPTH);
   localparam int unsigned CNT_BITS  = $clog2(RING_DEPTH + 1);
   localparam int unsigned NUM_BITS  = CNT_BITS + SCALE_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_WALK,
      ST_SETUP,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   function automatic logic [ADDR_BITS-1:0] slot_dec(input logic [ADDR_BITS-1:0] s);
      return (s == '0) ? ADDR_BITS'(RING_DEPTH - 1) : s - ADDR_BITS'(1);
   endfunction

   function automatic logic [ADDR_BITS-1:0] slot_inc(input logic [ADDR_BITS-1:0] s);
      return (s == ADDR_BITS'(RING_DEPTH - 1)) ? '0 : s + ADDR_BITS'(1);
   endfunction

   // control
   state_type            state_ff, state_in;
   logic [WINDOW_BITS-1:0] window_ff, window_in;
   logic [ADDR_BITS-1:0] newest_ff, newest_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 start_ff, start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   // per-request working registers
   logic [TIME_BITS-1:0] t_ff, t_in;
   logic [TIME_BITS-1:0] thr_ff, thr_in;
   logic                 ovf_ff, ovf_in;
   logic [CNT_BITS-1:0]  total_ff, total_in;
   logic [CNT_BITS-1:0]  rd_cnt_ff, rd_cnt_in;
   logic [ADDR_BITS-1:0] rd_addr_ff, rd_addr_in;
   logic [ADDR_BITS-1:0] wr_addr_ff, wr_addr_in;
   logic [CNT_BITS-1:0]  kept_ff, kept_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic                 have_past_ff, have_past_in;
   logic [TIME_BITS-1:0] past_ff, past_in;
   logic [TIME_BITS-1:0] last_kept_ff, last_kept_in;
   logic [NUM_BITS-1:0]  num_ff, num_in;
   logic [TIME_BITS-1:0] den_ff, den_in;
   logic                 zero_ff, zero_in;
   logic [RATE_BITS-1:0] rate_res_ff, rate_res_in;
   // response payload
   logic [RATE_BITS-1:0] rsp_rate_ff, rsp_rate_in;
   logic [CNT_BITS-1:0]  rsp_frames_ff, rsp_frames_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   // memory and divider hookup
   logic                 mem_we, mem_re;
   logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
   logic [TIME_BITS-1:0] mem_wdata, mem_rdata;
   div_status_type       div_status;
   logic [RATE_BITS-1:0] div_rate;

   logic                 req_fire, csr_write, keep, out_free, full;
   logic [TIME_BITS-1:0] window_ext, ref_stamp;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign window_ext = TIME_BITS'(window_ff);
   assign full      = (count_ff >= CNT_BITS'(RING_DEPTH));
   assign keep      = (mem_rdata >= thr_ff);
   assign ref_stamp = have_past_ff ? past_ff : last_kept_ff;

   // memory port usage
   always_comb begin
      mem_re    = (state_ff == ST_WALK) && (rd_cnt_ff != total_ff);
      mem_raddr = rd_addr_ff;
      if (state_ff == ST_INSERT) begin
         mem_we    = 1'b1;
         mem_waddr = newest_ff;
         mem_wdata = t_ff;
      end else begin
         mem_we    = (state_ff == ST_WALK) && rd_valid_ff && keep;
         mem_waddr = wr_addr_ff;
         mem_wdata = mem_rdata;
      end
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      window_in     = window_ff;
      newest_in     = newest_ff;
      count_in      = count_ff;
      start_in      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      t_in          = t_ff;
      thr_in        = thr_ff;
      ovf_in        = ovf_ff;
      total_in      = total_ff;
      rd_cnt_in     = rd_cnt_ff;
      rd_addr_in    = rd_addr_ff;
      wr_addr_in    = wr_addr_ff;
      kept_in       = kept_ff;
      rd_valid_in   = 1'b0;
      have_past_in  = have_past_ff;
      past_in       = past_ff;
      last_kept_in  = last_kept_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      zero_in       = zero_ff;
      rate_res_in   = rate_res_ff;
      rsp_rate_in   = rsp_rate_ff;
      rsp_frames_in = rsp_frames_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      if (csr_write && (csr_paddr[2] == CSR_IDX_WINDOW)) begin
         window_in = csr_pwdata[WINDOW_BITS-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               t_in      = req_timestamp_us;
               ovf_in    = full;
               total_in  = (full ? CNT_BITS'(RING_DEPTH - 1) : count_ff) + CNT_BITS'(1);
               newest_in = slot_inc(newest_ff);
               state_in  = ST_INSERT;
            end
         end
         ST_INSERT: begin
            // stamp goes in this cycle; set up the walk
            thr_in       = (t_ff > window_ext) ? t_ff - window_ext : '0;
            rd_cnt_in    = '0;
            rd_addr_in   = newest_ff;
            wr_addr_in   = newest_ff;
            kept_in      = '0;
            have_past_in = 1'b0;
            state_in     = ST_WALK;
         end
         ST_WALK: begin
            // issue reads newest to oldest
            rd_valid_in = mem_re;
            if (mem_re) begin
               rd_cnt_in  = rd_cnt_ff + CNT_BITS'(1);
               rd_addr_in = slot_dec(rd_addr_ff);
            end
            // evaluate returned stamp; kept ones are compacted in place
            if (rd_valid_ff) begin
               if (keep) begin
                  kept_in      = kept_ff + CNT_BITS'(1);
                  wr_addr_in   = slot_dec(wr_addr_ff);
                  last_kept_in = mem_rdata;
               end else if (!have_past_ff) begin
                  past_in      = mem_rdata;
                  have_past_in = 1'b1;
               end
            end
            if (!mem_re && !rd_valid_ff) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            count_in = kept_ff;
            num_in   = NUM_BITS'(kept_ff) * NUM_BITS'(SCALED_SECOND);
            den_in   = t_ff - ref_stamp;
            zero_in  = !(t_ff > ref_stamp);
            start_in = 1'b1;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               rate_res_in = zero_ff ? '0 : div_rate;
               state_in    = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_rate_in   = rate_res_ff;
               rsp_frames_in = count_ff;
               rsp_ovf_in    = ovf_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         newest_ff    <= '0;
         count_ff     <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         newest_ff    <= newest_in;
         count_ff     <= count_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t_ff          <= t_in;
      thr_ff        <= thr_in;
      ovf_ff        <= ovf_in;
      total_ff      <= total_in;
      rd_cnt_ff     <= rd_cnt_in;
      rd_addr_ff    <= rd_addr_in;
      wr_addr_ff    <= wr_addr_in;
      kept_ff       <= kept_in;
      rd_valid_ff   <= rd_valid_in;
      have_past_ff  <= have_past_in;
      past_ff       <= past_in;
      last_kept_ff  <= last_kept_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      zero_ff       <= zero_in;
      rate_res_ff   <= rate_res_in;
      rsp_rate_ff   <= rsp_rate_in;
      rsp_frames_ff <= rsp_frames_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   swfr_ring_mem #(
      .DEPTH (RING_DEPTH),
      .WIDTH (TIME_BITS)
   ) u_ring (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   swfr_divider #(
      .NUM_BITS (NUM_BITS),
      .DEN_BITS (TIME_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (num_ff),
      .divisor  (den_ff),
      .status   (div_status),
      .rate     (div_rate)
   );

   // outputs
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_rate_fps         = rsp_rate_ff;
   assign rsp_frames_in_window = rsp_frames_ff;
   assign rsp_ring_overflow    = rsp_ovf_ff;
   assign csr_pready           = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_WINDOW) ?
                       CSR_DATA_BITS'(window_ff) : '0;

   // checks
   `SWFR_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_BITS'(RING_DEPTH))
   `SWFR_ASSERT_IMPLY(a_walk_no_clash, mem_we && mem_re, mem_waddr != mem_raddr)
   `SWFR_ASSERT_IMPLY(a_kept_le_read, state_ff == ST_WALK, kept_ff <= rd_cnt_ff)
   `SWFR_ASSERT_IMPLY(a_rsp_nonempty, rsp_valid_ff, rsp_frames_ff != '0)
   `SWFR_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

endmodule

// ===== sim/swfr_rate_checker.sv =====
`timescale 1ns / 100ps

// Watches the request, response and CSR traffic of the frame-rate meter,
// predicts every response and compares it field by field.
module swfr_rate_checker #(
   parameter int unsigned RING_DEPTH = 64,
   parameter int unsigned TIME_BITS  = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [TIME_BITS-1:0]                req_timestamp_us,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [swfr_pkg::RATE_BITS-1:0]      rsp_rate_fps,
   input  logic [$clog2(RING_DEPTH+1)-1:0]     rsp_frames_in_window,
   input  logic                                rsp_ring_overflow,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [swfr_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [swfr_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input  logic [swfr_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   input  logic                                csr_pready,
   output int unsigned                         mismatches,
   output int unsigned                         pending,
   output int unsigned                         checked
);

   localparam int unsigned COUNT_BITS = $clog2(RING_DEPTH + 1);
   localparam int unsigned REPORT_MAX = 10;

   typedef struct packed {
      logic [swfr_pkg::RATE_BITS-1:0] rate;
      logic [COUNT_BITS-1:0]          frames;
      logic                           overflow;
   } rate_result_type;

   // predictor state
   logic [swfr_pkg::WINDOW_BITS-1:0] window;
   logic [TIME_BITS-1:0]             stamp_ring [RING_DEPTH];
   int unsigned                      head;
   int unsigned                      stored;

   rate_result_type rate_due_q [$];
   int unsigned  fail_n = 0;
   int unsigned  checked_n = 0;

   // Store one stamp, evict everything below newest - window, compute the rate.
   task automatic advance_window(input logic [TIME_BITS-1:0] stamp,
                                 output rate_result_type res);
      logic [TIME_BITS-1:0] kept_stamps [RING_DEPTH];
      logic [TIME_BITS-1:0] thr;
      logic [TIME_BITS-1:0] past;
      logic [TIME_BITS-1:0] v;
      logic [63:0]          diff;
      logic [63:0]          num;
      logic [63:0]          quo;
      int unsigned          kept;
      int unsigned          slot;
      bit                   have_past;
      bit                   ovf;
      kept = 0;
      have_past = 1'b0;
      ovf = 1'b0;
      past = '0;
      quo = '0;

      // full ring: oldest stamp goes
      if (stored >= RING_DEPTH) begin
         stored = RING_DEPTH - 1;
         ovf = 1'b1;
      end
      head = (head + 1) % RING_DEPTH;
      stamp_ring[head] = stamp;
      stored++;

      // threshold saturates at zero
      if (64'(stamp) > 64'(window)) thr = stamp - window;
      else thr = '0;

      // walk newest to oldest; first evicted stamp is the reference
      for (int unsigned i = 0; i < stored; i++) begin
         slot = (head + RING_DEPTH - i) % RING_DEPTH;
         v = stamp_ring[slot];
         if (v >= thr) begin
            kept_stamps[kept] = v;
            kept++;
         end else if (!have_past) begin
            past = v;
            have_past = 1'b1;
         end
      end
      // compact kept stamps in walk order
      for (int unsigned i = 0; i < kept; i++) begin
         slot = (head + RING_DEPTH - i) % RING_DEPTH;
         stamp_ring[slot] = kept_stamps[i];
      end
      stored = kept;
      if (!have_past) past = kept_stamps[kept - 1];

      // equal or out-of-order reference gives zero
      if (stamp > past) begin
         diff = 64'(stamp) - 64'(past);
         num = 64'(kept) * 64'(swfr_pkg::SCALED_SECOND);
         quo = num / diff;
         if (quo > 64'(swfr_pkg::RATE_MAX)) quo = 64'(swfr_pkg::RATE_MAX);
      end

      res.rate = quo[swfr_pkg::RATE_BITS-1:0];
      res.frames = COUNT_BITS'(kept);
      res.overflow = ovf;
   endtask

   always @(posedge clock) begin : watch
      rate_result_type got;
      rate_result_type want;
      if (reset) begin
         window = swfr_pkg::WINDOW_RESET;
         head = 0;
         stored = 0;
         rate_due_q.delete();
      end else begin
         // responses first: a request accepted this edge cannot answer yet
         if (rsp_valid && rsp_ready) begin
            got.rate = rsp_rate_fps;
            got.frames = rsp_frames_in_window;
            got.overflow = rsp_ring_overflow;
            checked_n++;
            if (rate_due_q.size() == 0) begin
               fail_n++;
               if (fail_n <= REPORT_MAX)
                  $display("response with nothing pending: rate %h frames %0d ovf %0d",
                           got.rate, got.frames, got.overflow);
            end else begin
               want = rate_due_q.pop_front();
               if (got.rate != want.rate || got.frames != want.frames ||
                   got.overflow != want.overflow) begin
                  fail_n++;
                  if (fail_n <= REPORT_MAX)
                     $display("rate mismatch at %0t: exp rate %h frames %0d ovf %0d,",
                              $realtime, want.rate, want.frames, want.overflow,
                              " got rate %h frames %0d ovf %0d",
                              got.rate, got.frames, got.overflow);
               end
            end
         end

         if (req_valid && req_ready) begin
            advance_window(req_timestamp_us, want);
            rate_due_q.push_back(want);
         end

         // CSR write: only index 0 exists, value masked to the window width
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[swfr_pkg::CSR_ADDR_BITS-1:2] == swfr_pkg::CSR_IDX_WINDOW)
            window = csr_pwdata[swfr_pkg::WINDOW_BITS-1:0];

         // CSR read-back of the window
         if (csr_psel && csr_penable && !csr_pwrite && csr_pready &&
             csr_paddr[swfr_pkg::CSR_ADDR_BITS-1:2] == swfr_pkg::CSR_IDX_WINDOW &&
             csr_prdata != swfr_pkg::CSR_DATA_BITS'(window)) begin
            fail_n++;
            if (fail_n <= REPORT_MAX)
               $display("window read-back mismatch: exp %h got %h",
                        swfr_pkg::CSR_DATA_BITS'(window), csr_prdata);
         end
      end
      pending <= rate_due_q.size();
      mismatches <= fail_n;
      checked <= checked_n;
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import swfr_pkg::*;

   localparam int unsigned RING_DEPTH = 64;
   localparam int unsigned TIME_BITS = 48;
   localparam int unsigned COUNT_BITS = $clog2(RING_DEPTH + 1);
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_WINDOW = CSR_ADDR_BITS'(4 * CSR_IDX_WINDOW);
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_UNMAPPED = CSR_ADDR_BITS'(4);
   localparam logic [WINDOW_BITS-1:0] WINDOW_MAX = '1;
   localparam logic [TIME_BITS-1:0] STAMP_MAX = '1;
   localparam logic CSR_WRITE = 1'b1;
   localparam logic CSR_READ = 1'b0;
   localparam int unsigned CYCLE_LIMIT = 1500000;
   localparam int unsigned LONG_HOLD = 1500;
   localparam int unsigned HOLD_AT_RESULT = 400;
   localparam int unsigned TAIL_CYCLES = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [TIME_BITS-1:0] req_timestamp_us = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [RATE_BITS-1:0] rsp_rate_fps;
   logic [COUNT_BITS-1:0] rsp_frames_in_window;
   logic rsp_ring_overflow;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic csr_pready;

   int unsigned mismatches;
   int unsigned pending;
   int unsigned checked;

   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned items_sent = 0;
   int unsigned phases_run = 0;
   logic [TIME_BITS-1:0] stamp_now = '0;

   always #5 clock = ~clock;

   sliding_window_frame_rate #(
      .RING_DEPTH(RING_DEPTH),
      .TIME_BITS(TIME_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_timestamp_us(req_timestamp_us),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_rate_fps(rsp_rate_fps),
      .rsp_frames_in_window(rsp_frames_in_window),
      .rsp_ring_overflow(rsp_ring_overflow),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   swfr_rate_checker #(
      .RING_DEPTH(RING_DEPTH),
      .TIME_BITS(TIME_BITS)
   ) rate_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_timestamp_us(req_timestamp_us),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_rate_fps(rsp_rate_fps),
      .rsp_frames_in_window(rsp_frames_in_window),
      .rsp_ring_overflow(rsp_ring_overflow),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .mismatches(mismatches),
      .pending(pending),
      .checked(checked)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending", cycle_count, pending);
         $display("FAIL sliding_window_frame_rate");
         $finish;
      end
   end

   // response side: random stall modes plus one long hold-off
   int unsigned rsp_seen = 0;
   int unsigned hold_left = 0;
   int unsigned mode_left = 0;
   int unsigned stall_mode = 0;
   int unsigned pat_cnt = 0;
   bit long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) rsp_seen <= rsp_seen + 1;
         pat_cnt <= pat_cnt + 1;
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && rsp_seen >= HOLD_AT_RESULT) begin
            long_hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode <= $urandom_range(0, 3);
               mode_left <= $urandom_range(20, 400);
            end else begin
               mode_left <= mode_left - 1;
            end
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 99) < 75);
               2: rsp_ready <= ($urandom_range(0, 99) < 25);
               default: rsp_ready <= (pat_cnt % 7) != 0;
            endcase
         end
      end
   end

   // offer one stamp, hold it until accepted, then maybe idle
   task automatic push_frame(input logic [TIME_BITS-1:0] stamp);
      req_valid <= 1'b1;
      req_timestamp_us <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   // stop offering and wait until every response is back
   task automatic drain_requests;
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // one APB transfer: setup, access, then back to idle
   task automatic csr_access(input logic wr, input logic [CSR_ADDR_BITS-1:0] addr,
                             input logic [CSR_DATA_BITS-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // next arrival stamp; dense mode packs many frames into one window
   function automatic logic [TIME_BITS-1:0] next_stamp(input logic [TIME_BITS-1:0] prev,
                                                       input logic [WINDOW_BITS-1:0] win,
                                                       input bit dense);
      logic [63:0] w;
      logic [63:0] step;
      int unsigned pick;
      w = 64'(win);
      pick = $urandom_range(0, 99);
      if (pick < 6) step = 0;
      else if (pick < 12) step = 1;
      else if (dense && pick < 85) step = 64'($urandom_range(0, 32'(w >> 8) + 1));
      else if (pick < 55) step = 64'($urandom_range(0, 32'(w >> 5) + 1));
      else if (pick < 75) step = 64'($urandom_range(0, 32'(w >> 2) + 1));
      else if (pick < 85) step = w + 64'($urandom_range(0, 2)) - 1;
      else if (pick < 92) step = 64'($urandom_range(0, 32'(w << 1)));
      else if (pick < 95) step = 64'($urandom);
      else if (pick < 97) return prev - TIME_BITS'($urandom_range(0, 32'(w)));
      else return {16'($urandom_range(0, 65535)), 32'($urandom)};
      return TIME_BITS'(64'(prev) + step);
   endfunction

   // reprogram the window between drained phases, then stream stamps
   task automatic run_phase(input logic [WINDOW_BITS-1:0] win, input bit dense,
                            input int unsigned count, input bit poke_unmapped);
      drain_requests();
      csr_access(CSR_WRITE, ADDR_WINDOW, {6'($urandom_range(0, 63)), win});
      csr_access(CSR_READ, ADDR_WINDOW, '0);
      if (poke_unmapped) begin
         csr_access(CSR_WRITE, ADDR_UNMAPPED, $urandom);
         csr_access(CSR_READ, ADDR_WINDOW, '0);
      end
      repeat (count) begin
         stamp_now = next_stamp(stamp_now, win, dense);
         push_frame(stamp_now);
      end
      phases_run++;
   endtask

   initial begin
      logic [TIME_BITS-1:0] directed_stamps [$];
      directed_stamps = '{
         48'd0, 48'd0, 48'd1, 48'd2, 48'd500, 48'd999999, 48'd1000000,
         48'd1000001, 48'd1000002, 48'd3000000, 48'd3000000, 48'd2999000,
         STAMP_MAX, STAMP_MAX, 48'd0, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: near-zero stamps, equal stamps, saturation, eviction,
      // out-of-order stamps and the top of the stamp range, reset window
      foreach (directed_stamps[i]) push_frame(directed_stamps[i]);
      stamp_now = directed_stamps[directed_stamps.size() - 1];

      run_phase(26'd1000000, 1'b0, 150, 1'b0);
      run_phase(26'd1000000, 1'b1, 200, 1'b0);
      run_phase(26'd1, 1'b0, 150, 1'b1);
      run_phase(WINDOW_MAX, 1'b1, 200, 1'b0);
      run_phase(WINDOW_MAX, 1'b0, 150, 1'b1);
      run_phase(26'd100, 1'b1, 150, 1'b0);
      run_phase(WINDOW_BITS'($urandom_range(1, 32'(WINDOW_MAX))), 1'($urandom_range(0, 1)),
                200, 1'b0);
      run_phase(26'd5000, 1'b0, 150, 1'b0);
      run_phase(26'd64, 1'b1, 150, 1'b1);
      run_phase(WINDOW_BITS'($urandom_range(1, 32'(WINDOW_MAX))), 1'b0, 230, 1'b0);

      drain_requests();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d frame stamps over %0d window settings plus a directed set",
               items_sent, phases_run);
      $display("checked %0d rate responses, %0d mismatches, %0d left pending",
               checked, mismatches, pending);
      if (mismatches == 0 && pending == 0) begin
         $display("PASS sliding_window_frame_rate");
      end else begin
         $display("FAIL sliding_window_frame_rate");
      end
      $finish;
   end

endmodule
